// ===== rtl/packet_class_counter_assert.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef PACKET_CLASS_COUNTER_ASSERT_SVH
`define PACKET_CLASS_COUNTER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PCC_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PCC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== rtl/pcc_pkg.sv =====
// Types and constants for the packet class counter.
// Used by the capture front, the classifier back and the top level.
`default_nettype none
package pcc_pkg;
    typedef enum logic [3:0] {
        CLS_OTHER = 4'd0, CLS_ARP = 4'd1, CLS_IP = 4'd2, CLS_TCP = 4'd3,
        CLS_SMTP = 4'd4, CLS_POP = 4'd5, CLS_HTTP = 4'd6, CLS_IMAP = 4'd7,
        CLS_DNS = 4'd8, CLS_UDP = 4'd9, CLS_ICMP = 4'd10
    } frame_class_t;
    localparam int NUM_COUNTS = 10;
    localparam int CNT_IP = 0;
    localparam int CNT_ARP = 1;
    localparam int CNT_BCAST = 2;
    localparam int CNT_ICMP = 3;
    localparam int CNT_TCP = 4;
    localparam int CNT_SMTP = 5;
    localparam int CNT_POP = 6;
    localparam int CNT_IMAP = 7;
    localparam int CNT_HTTP = 8;
    localparam int CNT_DNS = 9;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP = 16'h0806;
    localparam logic [7:0] PROTO_TCP = 8'h06;
    localparam logic [7:0] PROTO_UDP = 8'h11;
    localparam logic [7:0] PROTO_ICMP = 8'h01;
    localparam logic [15:0] PORT_SMTP = 16'd25;
    localparam logic [15:0] PORT_POP = 16'd110;
    localparam logic [15:0] PORT_HTTP = 16'd80;
    localparam logic [15:0] PORT_IMAP = 16'd143;
    localparam logic [15:0] PORT_DNS = 16'd53;
    localparam logic [7:0] FLAGS_PSH_ACK = 8'h18;
    localparam logic [7:0] FLAGS_FIN_ACK = 8'h11;
    localparam logic [7:0] FLAG_PSH = 8'h08;
    // Header fields the classifier needs, pulled out of a captured frame.
    typedef struct packed {
        logic        bcast;
        logic [15:0] ethertype;
        logic [7:0]  proto;
        logic [15:0] ip_len;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [63:0] kw;
    } hdr_t;
endpackage
`default_nettype wire

// ===== rtl/pcc_front.sv =====
// Capture front: collects frame bytes and emits a header summary on the last beat.
// Depends on pcc_pkg.
`default_nettype none
module pcc_front #(
    parameter int CAPTURE_BYTES = 74
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    input  wire logic          in_valid,
    output      logic          in_stall,
    output      logic          hdr_valid,
    output      pcc_pkg::hdr_t hdr,
    input  wire logic          hdr_stall
);
    localparam int PW = $clog2(CAPTURE_BYTES + 1);
    localparam int KB = 66;
    logic [PW-1:0] pos_reg;
    logic [7:0]    buf_reg [KB+8];
    logic          hdr_valid_reg;
    pcc_pkg::hdr_t hdr_reg;
    logic          take;
    logic [7:0]    b [KB+8];

    assign in_stall = hdr_valid_reg && hdr_stall;
    assign take = in_valid && !in_stall;
    assign hdr_valid = hdr_valid_reg;
    assign hdr = hdr_reg;

    // View of the buffer with the current beat merged in.
    always_comb
    begin
        for (int i = 0; i < KB + 8; i++) begin
            b[i] = (i < CAPTURE_BYTES && pos_reg == PW'(i)) ? data_byte : buf_reg[i];
        end
    end

    // Byte position and header buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
            for (int i = 0; i < KB + 8; i++) buf_reg[i] <= 8'd0;
        end else if (take) begin
            if (last_byte) begin
                pos_reg <= '0;
                for (int i = 0; i < KB + 8; i++) buf_reg[i] <= 8'd0;
            end else begin
                if (pos_reg < PW'(CAPTURE_BYTES)) pos_reg <= pos_reg + PW'(1);
                for (int i = 0; i < KB + 8; i++) buf_reg[i] <= b[i];
            end
        end
    end

    // Output register toward the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            hdr_valid_reg <= take && last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last_byte) begin
            hdr_reg.bcast <= (b[0] & b[1] & b[2] & b[3] & b[4] & b[5]) == 8'hFF;
            hdr_reg.ethertype <= {b[12], b[13]};
            hdr_reg.proto <= b[23];
            hdr_reg.ip_len <= {b[16], b[17]};
            hdr_reg.sport <= {b[34], b[35]};
            hdr_reg.dport <= {b[36], b[37]};
            hdr_reg.ack <= {b[42], b[43], b[44], b[45]};
            hdr_reg.flags <= b[47];
            hdr_reg.kw <= {b[66], b[67], b[68], b[69], b[70], b[71], b[72], b[73]};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pcc_queue.sv =====
// Two-entry queue between the capture front and the classifier back.
// Depends on pcc_pkg.
`default_nettype none
module pcc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    input  wire pcc_pkg::hdr_t wr_data,
    output      logic          wr_stall,
    output      logic          rd_valid,
    output      pcc_pkg::hdr_t rd_data,
    input  wire logic          rd_stall
);
    pcc_pkg::hdr_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr, rd;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ===== rtl/pcc_back.sv =====
// Classifier back: session heuristics, counters and the result register.
// Depends on pcc_pkg.
`default_nettype none
module pcc_back #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             hdr_valid,
    input  wire pcc_pkg::hdr_t    hdr,
    output      logic             hdr_stall,
    output      logic             res_valid,
    output      logic [3:0]       res_class,
    output      logic             res_bcast,
    output      logic [32*pcc_pkg::NUM_COUNTS-1:0] res_counts,
    input  wire logic             res_stall
);
    localparam int N = pcc_pkg::NUM_COUNTS;
    logic [COUNT_BITS-1:0] cnt_reg [N];
    logic [N-1:0] bump;
    logic smtp_auth_reg, smtp_data_reg, pop_list_reg;
    logic http_open_reg, http_held_reg, http_valid_reg;
    logic [31:0] smtp_ack_reg, pop_ack_reg, http_ack_reg;
    logic smtp_auth_next, smtp_data_next, pop_list_next;
    logic http_open_next, http_held_next, http_valid_next;
    logic [31:0] smtp_ack_next, pop_ack_next, http_ack_next;
    pcc_pkg::frame_class_t cls;
    logic res_valid_reg;
    logic take;
    logic [7:0] t [4];
    logic [7:0] r [8];
    logic [31:0] t4, r4;
    logic [23:0] t3, r3;
    logic p25, p110, p80, p143, p53, diff, hit;

    assign hdr_stall = res_valid_reg && res_stall;
    assign take = hdr_valid && !hdr_stall;
    assign res_valid = res_valid_reg;

    // Payload keyword bytes, upper-cased for the mail protocols.
    always_comb
    begin
        for (int i = 0; i < 8; i++) r[i] = hdr.kw[63-8*i -: 8];
        for (int i = 0; i < 4; i++)
            t[i] = (r[i] >= 8'h61 && r[i] <= 8'h7A) ? r[i] - 8'h20 : r[i];
        t4 = {t[0], t[1], t[2], t[3]};
        t3 = t4[31:8];
        r4 = {r[4], r[5], r[6], r[7]};
        r3 = {r[0], r[1], r[2]};
    end

    // Classification and session state update.
    always_comb
    begin
        cls = pcc_pkg::CLS_OTHER;
        bump = '0;
        smtp_auth_next = smtp_auth_reg; smtp_data_next = smtp_data_reg;
        smtp_ack_next = smtp_ack_reg; pop_list_next = pop_list_reg;
        pop_ack_next = pop_ack_reg; http_open_next = http_open_reg;
        http_held_next = http_held_reg; http_valid_next = http_valid_reg;
        http_ack_next = http_ack_reg;
        p25 = hdr.sport == pcc_pkg::PORT_SMTP || hdr.dport == pcc_pkg::PORT_SMTP;
        p110 = hdr.sport == pcc_pkg::PORT_POP || hdr.dport == pcc_pkg::PORT_POP;
        p80 = hdr.sport == pcc_pkg::PORT_HTTP || hdr.dport == pcc_pkg::PORT_HTTP;
        p143 = hdr.sport == pcc_pkg::PORT_IMAP || hdr.dport == pcc_pkg::PORT_IMAP;
        p53 = hdr.sport == pcc_pkg::PORT_DNS || hdr.dport == pcc_pkg::PORT_DNS;
        diff = 1'b1;
        for (int i = 0; i < 4; i++)
            if (smtp_ack_reg[8*i +: 8] == hdr.ack[8*i +: 8]) diff = 1'b0;
        hit = 1'b0;
        bump[pcc_pkg::CNT_BCAST] = hdr.bcast;
        if (hdr.ethertype == pcc_pkg::ETH_IPV4) begin
            bump[pcc_pkg::CNT_IP] = 1'b1;
            cls = pcc_pkg::CLS_IP;
            if (hdr.proto == pcc_pkg::PROTO_TCP) begin
                bump[pcc_pkg::CNT_TCP] = 1'b1;
                cls = pcc_pkg::CLS_TCP;
                if (p25) begin
                    hit = t3 == "220" || t4 == "EHLO" || t3 == "250" || t4 == "HELO"
                        || t4 == "AUTH" || smtp_auth_reg || t4 == "MAIL"
                        || t4 == "RCPT" || t4 == "DATA" || t3 == "354";
                    if (hit) begin
                        if (t3 == "250" && smtp_auth_reg) begin
                            smtp_auth_next = 1'b0;
                            smtp_data_next = 1'b0;
                        end
                        if (smtp_auth_next && smtp_data_next && diff) begin
                            hit = 1'b0;
                        end else begin
                            if (smtp_auth_next && !smtp_data_next) begin
                                smtp_ack_next = hdr.ack;
                                smtp_data_next = 1'b1;
                            end
                            bump[pcc_pkg::CNT_SMTP] = 1'b1;
                            cls = pcc_pkg::CLS_SMTP;
                            if (t3 == "354") smtp_auth_next = 1'b1;
                        end
                    end else if (t3 == "354") begin
                        smtp_auth_next = 1'b1;
                    end
                end else if (p110) begin
                    if (t3 == "+OK" || t4 == "USER" || t4 == "PASS" || t4 == "LIST"
                        || t4 == "RETR" || t4 == "QUIT" || t4 == "-ERR"
                        || (pop_list_reg && pop_ack_reg == hdr.ack)) begin
                        pop_list_next = r4 == "Scan";
                        if (r4 == "Scan") pop_ack_next = hdr.ack;
                        bump[pcc_pkg::CNT_POP] = 1'b1;
                        cls = pcc_pkg::CLS_POP;
                    end
                end else if (p80) begin
                    if (http_open_reg && !http_held_reg && (hdr.flags & pcc_pkg::FLAG_PSH) != 8'd0
                        && hdr.sport == pcc_pkg::PORT_HTTP) begin
                        http_ack_next = hdr.ack;
                        http_valid_next = 1'b1;
                        http_held_next = 1'b1;
                        hit = 1'b1;
                    end else if (http_open_reg && http_valid_reg && http_ack_reg == hdr.ack) begin
                        if (hdr.flags == pcc_pkg::FLAGS_FIN_ACK) begin
                            http_open_next = 1'b0;
                            http_valid_next = 1'b0;
                        end else begin
                            hit = 1'b1;
                        end
                    end else if (r3 == "GET" && !http_open_reg) begin
                        http_open_next = 1'b1;
                        hit = 1'b1;
                    end
                    if (hit) begin
                        bump[pcc_pkg::CNT_HTTP] = 1'b1;
                        cls = pcc_pkg::CLS_HTTP;
                    end
                end else if (p143) begin
                    if (hdr.ip_len > 16'd40 && hdr.flags == pcc_pkg::FLAGS_PSH_ACK) begin
                        bump[pcc_pkg::CNT_IMAP] = 1'b1;
                        cls = pcc_pkg::CLS_IMAP;
                    end
                end else if (p53) begin
                    bump[pcc_pkg::CNT_DNS] = 1'b1;
                    cls = pcc_pkg::CLS_DNS;
                end
            end else if (hdr.proto == pcc_pkg::PROTO_UDP) begin
                cls = pcc_pkg::CLS_UDP;
                if (p53) begin
                    bump[pcc_pkg::CNT_DNS] = 1'b1;
                    cls = pcc_pkg::CLS_DNS;
                end
            end else if (hdr.proto == pcc_pkg::PROTO_ICMP) begin
                bump[pcc_pkg::CNT_ICMP] = 1'b1;
                cls = pcc_pkg::CLS_ICMP;
            end
        end else if (hdr.ethertype == pcc_pkg::ETH_ARP) begin
            bump[pcc_pkg::CNT_ARP] = 1'b1;
            cls = pcc_pkg::CLS_ARP;
        end
    end

    // Session state, counters and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < N; i++) cnt_reg[i] <= '0;
            smtp_auth_reg <= 1'b0; smtp_data_reg <= 1'b0; smtp_ack_reg <= '0;
            pop_list_reg <= 1'b0; pop_ack_reg <= '0;
            http_open_reg <= 1'b0; http_held_reg <= 1'b0;
            http_valid_reg <= 1'b1; http_ack_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (!hdr_stall) res_valid_reg <= take;
            if (take) begin
                for (int i = 0; i < N; i++)
                    if (bump[i]) cnt_reg[i] <= cnt_reg[i] + COUNT_BITS'(1);
                smtp_auth_reg <= smtp_auth_next; smtp_data_reg <= smtp_data_next;
                smtp_ack_reg <= smtp_ack_next; pop_list_reg <= pop_list_next;
                pop_ack_reg <= pop_ack_next; http_open_reg <= http_open_next;
                http_held_reg <= http_held_next; http_valid_reg <= http_valid_next;
                http_ack_reg <= http_ack_next;
            end
        end
    end

    // Result payload, taken with the counts after this frame's update.
    always_ff @(posedge clk)
    begin
        if (take) begin
            res_class <= cls;
            res_bcast <= hdr.bcast;
            for (int i = 0; i < N; i++)
                res_counts[32*i +: 32] <=
                    32'(COUNT_BITS'(cnt_reg[i] + COUNT_BITS'(bump[i])));
        end
    end
endmodule
`default_nettype wire

// ===== rtl/packet_class_counter.sv =====
// Packet class counter: Ethernet frame classifier with ten wrapping counters.
// Top level; uses pcc_pkg, pcc_front, pcc_queue and pcc_back.
//
// Usage: frame bytes enter on data_byte with last_byte marking the final beat,
// one beat per cycle while in_valid is high and in_stall low. Only the last
// beat of a frame produces a result beat on out_valid: frame_class,
// is_broadcast and all ten counts after this frame's update.
// Path: the last byte's header summary loads the front output register, then
// the two-entry queue, then the back result register, which drives out_valid.
// Throughput: one byte per cycle sustained while out_stall stays low; the
// classifier handles one frame per cycle, so back-to-back one-byte frames also
// run at full rate.
// When out_stall holds, the result register holds, the queue fills, and
// in_stall rises once the front's own output register is also full.
// Reset clears the counters and the capture buffer and resets the session state at once.
`default_nettype none
module packet_class_counter #(
    parameter int CAPTURE_BYTES = 74,
    parameter int COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [3:0]  frame_class,
    output      logic        is_broadcast,
    output      logic [31:0] ip_count,
    output      logic [31:0] arp_count,
    output      logic [31:0] broadcast_count,
    output      logic [31:0] icmp_count,
    output      logic [31:0] tcp_count,
    output      logic [31:0] smtp_count,
    output      logic [31:0] pop_count,
    output      logic [31:0] imap_count,
    output      logic [31:0] http_count,
    output      logic [31:0] dns_count
);
    pcc_pkg::hdr_t f_hdr, q_hdr;
    logic f_valid, f_stall, q_valid, q_stall;
    logic [32*pcc_pkg::NUM_COUNTS-1:0] counts;

    pcc_front #(.CAPTURE_BYTES(CAPTURE_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .data_byte(data_byte), .last_byte(last_byte),
        .in_valid(in_valid), .in_stall(in_stall), .hdr_valid(f_valid),
        .hdr(f_hdr), .hdr_stall(f_stall)
    );

    pcc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_data(f_hdr),
        .wr_stall(f_stall), .rd_valid(q_valid), .rd_data(q_hdr), .rd_stall(q_stall)
    );

    pcc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .hdr_valid(q_valid), .hdr(q_hdr),
        .hdr_stall(q_stall), .res_valid(out_valid), .res_class(frame_class),
        .res_bcast(is_broadcast), .res_counts(counts), .res_stall(out_stall)
    );

    assign ip_count        = counts[32*pcc_pkg::CNT_IP    +: 32];
    assign arp_count       = counts[32*pcc_pkg::CNT_ARP   +: 32];
    assign broadcast_count = counts[32*pcc_pkg::CNT_BCAST +: 32];
    assign icmp_count      = counts[32*pcc_pkg::CNT_ICMP  +: 32];
    assign tcp_count       = counts[32*pcc_pkg::CNT_TCP   +: 32];
    assign smtp_count      = counts[32*pcc_pkg::CNT_SMTP  +: 32];
    assign pop_count       = counts[32*pcc_pkg::CNT_POP   +: 32];
    assign imap_count      = counts[32*pcc_pkg::CNT_IMAP  +: 32];
    assign http_count      = counts[32*pcc_pkg::CNT_HTTP  +: 32];
    assign dns_count       = counts[32*pcc_pkg::CNT_DNS   +: 32];
endmodule
`default_nettype wire

// ===== rtl/pcc_checker.sv =====
// Port-level checker for the packet class counter, bound to the top level.
// Depends on packet_class_counter_assert.svh.
`default_nettype none
`include "packet_class_counter_assert.svh"
module pcc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [3:0]  frame_class,
    input wire logic        is_broadcast,
    input wire logic [31:0] ip_count,
    input wire logic [31:0] broadcast_count,
    input wire logic [31:0] arp_count
);
    // A stalled result beat stays put.
    `PCC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(frame_class))
    // An IP-family class is never reported with a zero IP count.
    `PCC_ASSERT_IMPL(a_ip, clk, rst_n, out_valid && frame_class >= pcc_pkg::CLS_IP, ip_count != 32'd0)
    // A broadcast frame means the broadcast count has moved off zero.
    `PCC_ASSERT_IMPL(a_bc, clk, rst_n, out_valid && is_broadcast, broadcast_count != 32'd0)
    // An ARP class means the ARP count is nonzero.
    `PCC_ASSERT_IMPL(a_arp, clk, rst_n, out_valid && frame_class == pcc_pkg::CLS_ARP, arp_count != 32'd0)
endmodule
bind packet_class_counter pcc_checker u_pcc_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .frame_class(frame_class), .is_broadcast(is_broadcast), .ip_count(ip_count),
    .broadcast_count(broadcast_count), .arp_count(arp_count)
);
`default_nettype wire

// ===== dv/tb_packet_class_counter.sv =====
// Self-checking testbench for packet_class_counter: drives byte beats, predicts each result.
// Depends on rtl/pcc_pkg.sv, rtl/packet_class_counter.sv and its blocks pcc_front, pcc_queue and pcc_back.
`default_nettype none

// Scoreboard: tracks the capture buffer and session state and queues expected result beats.
class frame_scoreboard;
    localparam int CAP = 74;

    typedef struct {
        pcc_pkg::frame_class_t cls;
        bit                    bcast;
        bit [9:0][31:0]        counts;
    } frame_result_t;

    bit [7:0]       hdr[CAP];
    int             pos;
    bit [9:0][31:0] counts;
    bit             smtp_auth, smtp_data, pop_list;
    bit             http_open, http_ack_held, http_ack_valid;
    bit [31:0]      smtp_ack, pop_ack, http_ack;
    frame_result_t  pending_q[$];
    int             errors;
    int             results;
    int             class_hits[11];

    function void clear();
        pos = 0;
        foreach (hdr[i]) hdr[i] = 8'h00;
        counts = '0;
        smtp_auth = 0; smtp_data = 0; smtp_ack = 0;
        pop_list = 0; pop_ack = 0;
        http_open = 0; http_ack_held = 0; http_ack = 0; http_ack_valid = 1;
        errors = 0;
        results = 0;
        foreach (class_hits[i]) class_hits[i] = 0;
    endfunction

    function int pending();
        return pending_q.size();
    endfunction

    // Bytes past the captured part of the frame read as zero.
    function bit [7:0] hb(int i);
        return (i < CAP) ? hdr[i] : 8'h00;
    endfunction

    function bit [15:0] hw16(int i);
        return {hb(i), hb(i + 1)};
    endfunction

    function void bump(int k);
        counts[k] = counts[k] + 1;
    endfunction

    function bit all_differ(bit [31:0] a, bit [31:0] b);
        for (int s = 0; s < 4; s++)
            if (a[s*8 +: 8] == b[s*8 +: 8])
                return 0;
        return 1;
    endfunction

    // Port heuristics for TCP frames; updates the session state as a side effect.
    function pcc_pkg::frame_class_t classify_tcp();
        bit [15:0] sp, dp;
        bit [31:0] ack, tw;
        bit [7:0]  flags, c;
        bit        k250, k354, hit;
        sp = hw16(34);
        dp = hw16(36);
        ack = {hb(42), hb(43), hb(44), hb(45)};
        flags = hb(47);
        for (int i = 0; i < 4; i++)
        begin
            c = hb(66 + i);
            tw[31 - i*8 -: 8] = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
        end
        if (sp == pcc_pkg::PORT_SMTP || dp == pcc_pkg::PORT_SMTP)
        begin
            k250 = (tw[31:8] == "250");
            k354 = (tw[31:8] == "354");
            hit = tw[31:8] == "220" || tw == "EHLO" || k250 || tw == "HELO" ||
                  tw == "AUTH" || smtp_auth || tw == "MAIL" || tw == "RCPT" ||
                  tw == "DATA" || k354;
            if (hit)
            begin
                if (k250 && smtp_auth)
                begin
                    smtp_auth = 0;
                    smtp_data = 0;
                end
                // Out-of-session frame while a DATA transfer is tracked is skipped.
                if (smtp_auth && smtp_data && all_differ(smtp_ack, ack))
                    return pcc_pkg::CLS_TCP;
                if (smtp_auth && !smtp_data)
                begin
                    smtp_ack = ack;
                    smtp_data = 1;
                end
                bump(pcc_pkg::CNT_SMTP);
            end
            if (k354)
                smtp_auth = 1;
            return hit ? pcc_pkg::CLS_SMTP : pcc_pkg::CLS_TCP;
        end
        if (sp == pcc_pkg::PORT_POP || dp == pcc_pkg::PORT_POP)
        begin
            hit = tw[31:8] == "+OK" || tw == "USER" || tw == "PASS" || tw == "LIST" ||
                  tw == "RETR" || tw == "QUIT" || tw == "-ERR" ||
                  (pop_list && pop_ack == ack);
            if (!hit)
                return pcc_pkg::CLS_TCP;
            pop_list = 0;
            if ({hb(70), hb(71), hb(72), hb(73)} == "Scan")
            begin
                pop_list = 1;
                pop_ack = ack;
            end
            bump(pcc_pkg::CNT_POP);
            return pcc_pkg::CLS_POP;
        end
        if (sp == pcc_pkg::PORT_HTTP || dp == pcc_pkg::PORT_HTTP)
        begin
            if (http_open && !http_ack_held && (flags & pcc_pkg::FLAG_PSH) != 0 &&
                sp == pcc_pkg::PORT_HTTP)
            begin
                http_ack = ack;
                http_ack_valid = 1;
                http_ack_held = 1;
            end
            else if (http_open && http_ack_valid && http_ack == ack)
            begin
                // A FIN on the tracked session closes it without counting.
                if (flags == pcc_pkg::FLAGS_FIN_ACK)
                begin
                    http_open = 0;
                    http_ack_valid = 0;
                    return pcc_pkg::CLS_TCP;
                end
            end
            else if ({hb(66), hb(67), hb(68)} == "GET" && !http_open)
                http_open = 1;
            else
                return pcc_pkg::CLS_TCP;
            bump(pcc_pkg::CNT_HTTP);
            return pcc_pkg::CLS_HTTP;
        end
        if (sp == pcc_pkg::PORT_IMAP || dp == pcc_pkg::PORT_IMAP)
        begin
            if (hw16(16) > 40 && flags == pcc_pkg::FLAGS_PSH_ACK)
            begin
                bump(pcc_pkg::CNT_IMAP);
                return pcc_pkg::CLS_IMAP;
            end
            return pcc_pkg::CLS_TCP;
        end
        if (sp == pcc_pkg::PORT_DNS || dp == pcc_pkg::PORT_DNS)
        begin
            bump(pcc_pkg::CNT_DNS);
            return pcc_pkg::CLS_DNS;
        end
        return pcc_pkg::CLS_TCP;
    endfunction

    // Notes one accepted input beat; the last beat of a frame queues a result.
    function void note_byte(bit [7:0] d, bit last);
        frame_result_t r;
        bit [15:0]     et;
        bit [7:0]      proto;
        if (pos < CAP)
        begin
            hdr[pos] = d;
            pos++;
        end
        if (!last)
            return;
        r.bcast = 1;
        for (int i = 0; i < 6; i++)
            if (hb(i) != 8'hFF)
                r.bcast = 0;
        if (r.bcast)
            bump(pcc_pkg::CNT_BCAST);
        r.cls = pcc_pkg::CLS_OTHER;
        et = hw16(12);
        if (et == pcc_pkg::ETH_IPV4)
        begin
            proto = hb(23);
            bump(pcc_pkg::CNT_IP);
            r.cls = pcc_pkg::CLS_IP;
            if (proto == pcc_pkg::PROTO_TCP)
            begin
                bump(pcc_pkg::CNT_TCP);
                r.cls = classify_tcp();
            end
            else if (proto == pcc_pkg::PROTO_UDP)
            begin
                r.cls = pcc_pkg::CLS_UDP;
                if (hw16(34) == pcc_pkg::PORT_DNS || hw16(36) == pcc_pkg::PORT_DNS)
                begin
                    bump(pcc_pkg::CNT_DNS);
                    r.cls = pcc_pkg::CLS_DNS;
                end
            end
            else if (proto == pcc_pkg::PROTO_ICMP)
            begin
                bump(pcc_pkg::CNT_ICMP);
                r.cls = pcc_pkg::CLS_ICMP;
            end
        end
        else if (et == pcc_pkg::ETH_ARP)
        begin
            bump(pcc_pkg::CNT_ARP);
            r.cls = pcc_pkg::CLS_ARP;
        end
        r.counts = counts;
        pending_q.push_back(r);
        class_hits[r.cls]++;
        pos = 0;
        foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_result(bit [3:0] cls, bit bcast, bit [9:0][31:0] got);
        frame_result_t r;
        string         names[10];
        names = '{"ip_count", "arp_count", "broadcast_count", "icmp_count", "tcp_count",
                  "smtp_count", "pop_count", "imap_count", "http_count", "dns_count"};
        results++;
        if (pending_q.size() == 0)
        begin
            $error("result beat with no frame outstanding");
            errors++;
            return;
        end
        r = pending_q.pop_front();
        if (cls != r.cls)
        begin
            $error("frame_class: expected %0d, got %0d", r.cls, cls);
            errors++;
        end
        if (bcast != r.bcast)
        begin
            $error("is_broadcast: expected %0d, got %0d", r.bcast, bcast);
            errors++;
        end
        for (int k = 0; k < 10; k++)
            if (got[k] != r.counts[k])
            begin
                $error("%s: expected %0d, got %0d", names[k], r.counts[k], got[k]);
                errors++;
            end
    endfunction
endclass

module tb_packet_class_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int BYTE_TARGET = 1700;
    localparam int HOLD_CYCLES = 600;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  data_byte = 0;
    logic        last_byte = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [3:0]  frame_class;
    logic        is_broadcast;
    logic [31:0] ip_count, arp_count, broadcast_count, icmp_count, tcp_count;
    logic [31:0] smtp_count, pop_count, imap_count, http_count, dns_count;

    frame_scoreboard sb = new();
    int          bytes_sent;
    int          idle_cycles;
    bit          tx_gaps;
    bit          rx_gaps;
    int          long_hold;
    int          rx_wait;
    logic [7:0]  frame_q[$];

    packet_class_counter uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .frame_class(frame_class), .is_broadcast(is_broadcast),
        .ip_count(ip_count), .arp_count(arp_count), .broadcast_count(broadcast_count),
        .icmp_count(icmp_count), .tcp_count(tcp_count), .smtp_count(smtp_count),
        .pop_count(pop_count), .imap_count(imap_count), .http_count(http_count),
        .dns_count(dns_count)
    );

    always #1 clk = ~clk;

    // Monitor both channels and watch for a hung handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && !in_stall)
            begin
                sb.note_byte(data_byte, last_byte);
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(frame_class, is_broadcast,
                    {dns_count, http_count, imap_count, pop_count, smtp_count, tcp_count,
                     icmp_count, broadcast_count, arp_count, ip_count});
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without a beat", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stall after each result beat when gaps are on, plus one long hold-off.
    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            out_stall <= 1;
            long_hold--;
        end
        else if (rx_wait > 0)
        begin
            out_stall <= 1;
            rx_wait--;
        end
        else
        begin
            out_stall <= 0;
            if (out_valid && !out_stall && rx_gaps)
                rx_wait = $urandom_range(0, 10);
        end
    end

    // Sends one byte beat, with a random gap ahead of it when gaps are on.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Builds a frame of random bytes, then lays the header fields over it.
    task automatic build_frame(input int len, input bit bcast, input logic [15:0] et,
                               input logic [7:0] proto, input logic [15:0] sp,
                               input logic [15:0] dp, input logic [31:0] ack,
                               input logic [7:0] flags, input logic [15:0] iplen,
                               input logic [31:0] kw, input bit scan);
        logic [7:0] f[80];
        foreach (f[i]) f[i] = 8'($urandom_range(0, 255));
        if (bcast)
            for (int i = 0; i < 6; i++) f[i] = 8'hFF;
        {f[12], f[13]} = et;
        {f[16], f[17]} = iplen;
        f[23] = proto;
        {f[34], f[35]} = sp;
        {f[36], f[37]} = dp;
        {f[42], f[43], f[44], f[45]} = ack;
        f[47] = flags;
        {f[66], f[67], f[68], f[69]} = kw;
        if (scan)
            {f[70], f[71], f[72], f[73]} = "Scan";
        frame_q.delete();
        for (int i = 0; i < len; i++)
            frame_q.push_back(i < 80 ? f[i] : 8'($urandom_range(0, 255)));
    endtask

    task automatic tcp_frame(input logic [15:0] sp, input logic [15:0] dp,
                             input logic [31:0] kw, input logic [31:0] ack,
                             input logic [7:0] flags, input bit scan);
        build_frame(74, 0, pcc_pkg::ETH_IPV4, pcc_pkg::PROTO_TCP, sp, dp, ack, flags,
                    16'd60, kw, scan);
        send_frame();
    endtask

    // Picks a field value from a small pool so that sessions line up often.
    function automatic logic [31:0] pick_ack();
        case ($urandom_range(0, 4))
            0: return 32'h11223344;
            1: return 32'h11AABBCC;
            2: return 32'h55667788;
            3: return 32'h99AABBCC;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 6))
            0: return pcc_pkg::PORT_SMTP;
            1: return pcc_pkg::PORT_POP;
            2: return pcc_pkg::PORT_HTTP;
            3: return pcc_pkg::PORT_IMAP;
            4: return pcc_pkg::PORT_DNS;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_keyword();
        logic [31:0] kw;
        case ($urandom_range(0, 19))
            0: kw = "220 ";  1: kw = "EHLO";  2: kw = "250 ";  3: kw = "HELO";
            4: kw = "AUTH";  5: kw = "MAIL";  6: kw = "RCPT";  7: kw = "DATA";
            8: kw = "354 ";  9: kw = "+OK "; 10: kw = "USER"; 11: kw = "PASS";
            12: kw = "LIST"; 13: kw = "RETR"; 14: kw = "QUIT"; 15: kw = "-ERR";
            16: kw = "GET "; 17: kw = "get ";
            default: kw = $urandom();
        endcase
        // Lower-case some letters to exercise the case folding.
        for (int i = 0; i < 4; i++)
            if (kw[i*8 +: 8] >= 8'h41 && kw[i*8 +: 8] <= 8'h5A && $urandom_range(0, 3) == 0)
                kw[i*8 +: 8] = kw[i*8 +: 8] | 8'h20;
        return kw;
    endfunction

    task automatic random_frame();
        logic [15:0] et, sp, dp, iplen;
        logic [7:0]  proto, flags;
        int          len, pick;
        pick = $urandom_range(0, 9);
        et = pick < 7 ? pcc_pkg::ETH_IPV4 : pick < 8 ? pcc_pkg::ETH_ARP :
             16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 19);
        proto = pick < 12 ? pcc_pkg::PROTO_TCP : pick < 15 ? pcc_pkg::PROTO_UDP :
                pick < 17 ? pcc_pkg::PROTO_ICMP : 8'($urandom_range(0, 255));
        sp = pick_port();
        dp = pick_port();
        pick = $urandom_range(0, 4);
        flags = pick == 0 ? pcc_pkg::FLAGS_PSH_ACK : pick == 1 ? pcc_pkg::FLAGS_FIN_ACK :
                pick == 2 ? pcc_pkg::FLAG_PSH : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 2);
        iplen = pick == 0 ? 16'd40 : pick == 1 ? 16'd41 : 16'($urandom_range(0, 65535));
        // Mostly full-length frames; some short ones and a few past the capture size.
        pick = $urandom_range(0, 9);
        len = pick < 3 ? $urandom_range(1, 70) : pick < 9 ? $urandom_range(67, 76) :
              $urandom_range(77, 100);
        build_frame(len, $urandom_range(0, 4) == 0, et, proto, sp, dp, pick_ack(), flags,
                    iplen, pick_keyword(), $urandom_range(0, 2) == 0);
        send_frame();
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int frames;
        sb.clear();
        tx_gaps = 1;
        rx_gaps = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed frames: ARP, other, IP, UDP, DNS, ICMP and the extremes.
        build_frame(60, 1, pcc_pkg::ETH_ARP, 8'h00, 0, 0, 0, 0, 0, 0, 0);
        send_frame();
        build_frame(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        frame_q[0] = 8'hFF;
        send_frame();
        build_frame(100, 0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF,
                    16'hFFFF, 32'hFFFFFFFF, 0);
        send_frame();
        build_frame(14, 1, pcc_pkg::ETH_IPV4, 0, 0, 0, 0, 0, 0, 0, 0);
        send_frame();
        build_frame(74, 0, pcc_pkg::ETH_IPV4, pcc_pkg::PROTO_UDP, 16'd53, 16'd9, 0, 0, 0, 0, 0);
        send_frame();
        build_frame(74, 0, pcc_pkg::ETH_IPV4, pcc_pkg::PROTO_UDP, 16'd7, 16'd9, 0, 0, 0, 0, 0);
        send_frame();
        build_frame(74, 0, pcc_pkg::ETH_IPV4, pcc_pkg::PROTO_ICMP, 0, 0, 0, 0, 0, 0, 0);
        send_frame();

        // The receiver holds off for a long stretch while mail frames go in back to back.
        tx_gaps = 0;
        long_hold = HOLD_CYCLES;
        tcp_frame(16'd1000, pcc_pkg::PORT_SMTP, "ehlo", 32'h11223344, 0, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_SMTP, "354 ", 32'h11223344, 0, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_SMTP, "xxxx", 32'h55667788, 0, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_SMTP, "xxxx", 32'h99AABBCC, 0, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_SMTP, "250 ", 32'h55667788, 0, 0);
        tcp_frame(pcc_pkg::PORT_POP, pcc_pkg::PORT_SMTP, "-ERR", 0, 0, 0);
        tcp_frame(pcc_pkg::PORT_POP, 16'd1000, "list", 32'h12345678, 0, 1);
        tcp_frame(16'd1000, pcc_pkg::PORT_POP, "zzzz", 32'h12345678, 0, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_POP, "zzzz", 32'h12345678, 0, 0);

        // The sender pauses until every outstanding result has come back.
        tx_gaps = 1;
        in_valid <= 0;
        wait_drained();

        // Directed session sequences for the web and the remaining ports.
        tcp_frame(16'd1000, pcc_pkg::PORT_HTTP, "GET ", 32'hA0A0A0A0, 0, 0);
        tcp_frame(pcc_pkg::PORT_HTTP, 16'd1000, "xxxx", 32'hB0B0B0B0, pcc_pkg::FLAG_PSH, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_HTTP, "xxxx", 32'hB0B0B0B0,
                  pcc_pkg::FLAGS_FIN_ACK, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_HTTP, "xxxx", 32'hB0B0B0B0, 0, 0);
        tcp_frame(pcc_pkg::PORT_IMAP, 16'd1000, "xxxx", 0, pcc_pkg::FLAGS_PSH_ACK, 0);
        tcp_frame(16'd1000, pcc_pkg::PORT_DNS, "xxxx", 0, 0, 0);
        tcp_frame(16'd1000, 16'd1001, "xxxx", 0, 0, 0);
        build_frame(74, 0, pcc_pkg::ETH_IPV4, 8'h2F, 0, 0, 0, 0, 0, 0, 0);
        send_frame();

        // Random frames with changing idle patterns on both sides.
        frames = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            if (frames % 8 == 0)
            begin
                tx_gaps = $urandom_range(0, 2) != 0;
                rx_gaps = $urandom_range(0, 2) != 0;
            end
            random_frame();
            frames++;
        end
        in_valid <= 0;

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d byte beats in %0d random frames plus directed frames; %0d results.",
                 bytes_sent, frames, sb.results);
        $display("Results per class: arp %0d ip %0d tcp %0d smtp %0d pop %0d http %0d imap %0d",
                 sb.class_hits[1], sb.class_hits[2], sb.class_hits[3], sb.class_hits[4],
                 sb.class_hits[5], sb.class_hits[6], sb.class_hits[7]);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_front.sv
rtl/pcc_queue.sv
rtl/pcc_back.sv
rtl/packet_class_counter.sv
rtl/pcc_checker.sv
dv/tb_packet_class_counter.sv
